>>> src/kvs_pkg.sv
`default_nettype none

package kvs_pkg;

   localparam int MAX_KEYS_DEFAULT = 64;
   localparam int CSR_W = 7;
   localparam int FRAC_W = 16;
   localparam int SLOT_W = 6;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef struct packed {
      logic         command;
      logic [5:0]   key_index;
      logic [31:0]  key_time;
      logic signed [31:0] key_x;
      logic signed [31:0] key_y;
      logic signed [31:0] key_z;
      logic [31:0]  query_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_x;
      logic signed [31:0] value_y;
      logic signed [31:0] value_z;
      logic [5:0]   lower_index;
      logic [5:0]   upper_index;
      logic [15:0]  blend_fraction;
   } rsp_type;

   // One table row: the key time and the three value components.
   typedef struct packed {
      logic [31:0] key_time;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } entry_type;

endpackage

`default_nettype wire

>>> src/kvs_ram.sv
`default_nettype none

module kvs_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> src/keyframe_vec3_sampler_core.sv
`default_nettype none

// Keyframe sampler. A write command stores one key (time and x, y, z) at the edge that
// accepts it and leaves busy low. A sample command raises busy, and its result beat comes
// in the first cycle that busy is low again. How long busy stays high depends on the
// path: an empty table, a table of one key or a query at or before key 0, a query at or
// after the last key, or otherwise a binary search of p probes, at most ceil(log2(n-1))
// for n keys. The busy time is set by the single read port of the key table (each
// probe of the binary search takes a read state and a check state), the serial divider
// that makes one fraction bit a cycle, and the one multiplier that serves the three
// components in turn.
// Each result appears for exactly one cycle with rsp_valid; the receiver cannot
// stall it and must take the beat then. key_count must be written through the csr port
// only while the block is idle; the block does not enforce it. csr_ready is always high.
module keyframe_vec3_sampler_core #(
   parameter int MAX_KEYS = kvs_pkg::MAX_KEYS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire kvs_pkg::req_type              req_data,
   output logic                               rsp_valid,
   output kvs_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [kvs_pkg::CSR_W-1:0]     csr_data
);

   import kvs_pkg::*;

   localparam int IW = $clog2(MAX_KEYS);
   localparam int CW = (IW + 1 > CSR_W) ? IW + 1 : CSR_W;
   localparam int DCW = $clog2(FRAC_W);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_PROBE,
      S_PROBE_CHK,
      S_DIV,
      S_MUL,
      S_ACC
   } state_type;

   state_type        state_ff;
   logic [CSR_W-1:0] key_count_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic [31:0]      query_ff;
   logic [IW-1:0]    last_ff;
   logic             single_ff;
   logic [IW-1:0]    lo_ff;
   logic [IW-1:0]    hi_ff;
   logic [IW-1:0]    mid_ff;
   entry_type        lo_entry_ff;
   entry_type        hi_entry_ff;
   logic [31:0]      rem_ff;
   logic [31:0]      den_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic [DCW-1:0]   div_cnt_ff;
   logic [1:0]       comp_ff;
   logic signed [49:0] prod_ff;

   logic             accept;
   logic [CW-1:0]    count_ext;
   logic [IW-1:0]    last_in;
   logic             wr_en;
   logic [IW-1:0]    rd_addr;
   entry_type        rd_data;
   entry_type        wr_entry;
   logic [IW:0]      mid_sum;
   logic [IW-1:0]    mid;
   logic [32:0]      rem_shift;
   logic             rem_ge;
   logic [31:0]      num_in;
   logic [31:0]      den_in;
   logic             div_ok;
   logic [31:0]      v0;
   logic [31:0]      v1;
   logic signed [32:0] delta;
   logic signed [16:0] frac_s;
   logic signed [49:0] prod_in;
   logic [31:0]      comp_result;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Effective count is key_count saturated to the table size; last_in is count - 1.
   assign count_ext = CW'(key_count_ff);
   assign last_in   = (count_ext >= CW'(MAX_KEYS)) ? IW'(MAX_KEYS - 1)
                                                   : IW'(count_ext - CW'(1));

   assign wr_en = accept && (req_data.command == CMD_WRITE)
                  && (32'(req_data.key_index) < 32'(MAX_KEYS));

   assign wr_entry.key_time = req_data.key_time;
   assign wr_entry.x        = req_data.key_x;
   assign wr_entry.y        = req_data.key_y;
   assign wr_entry.z        = req_data.key_z;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IW:1];

   always_comb begin
      unique case (state_ff)
         S_FIRST: rd_addr = last_ff;
         S_PROBE: rd_addr = mid;
         default: rd_addr = '0;
      endcase
   end

   kvs_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(MAX_KEYS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(IW'(req_data.key_index)),
      .wr_data(wr_entry),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Divider setup from the bracketing pair; the remainder starts below the gap.
   assign num_in = query_ff - lo_entry_ff.key_time;
   assign den_in = hi_entry_ff.key_time - lo_entry_ff.key_time;
   assign div_ok = (hi_entry_ff.key_time > lo_entry_ff.key_time)
                   && (query_ff >= lo_entry_ff.key_time);

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, den_ff});

   // Shared multiplier: one component per pass, (v1 - v0) * fraction.
   always_comb begin
      unique case (comp_ff)
         2'd0: begin
            v0 = lo_entry_ff.x;
            v1 = hi_entry_ff.x;
         end
         2'd1: begin
            v0 = lo_entry_ff.y;
            v1 = hi_entry_ff.y;
         end
         default: begin
            v0 = lo_entry_ff.z;
            v1 = hi_entry_ff.z;
         end
      endcase
   end

   assign delta       = $signed({v1[31], v1}) - $signed({v0[31], v0});
   assign frac_s      = $signed({1'b0, frac_ff});
   assign prod_in     = 50'(delta) * 50'(frac_s);
   // Arithmetic shift by 16 floors toward minus infinity, as the interpolation needs.
   assign comp_result = v0 + prod_ff[47:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_ACC) && (comp_ff == 2'd2);
         if (csr_valid && csr_ready) begin
            key_count_ff <= csr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && (req_data.command == CMD_SAMPLE)) begin
                  query_ff  <= req_data.query_time;
                  last_ff   <= last_in;
                  single_ff <= (count_ext == CW'(1));
                  frac_ff   <= '0;
                  comp_ff   <= '0;
                  lo_ff     <= '0;
                  hi_ff     <= '0;
                  if (key_count_ff == '0) begin
                     lo_entry_ff <= '0;
                     hi_entry_ff <= '0;
                     state_ff    <= S_MUL;
                  end else begin
                     state_ff <= S_FIRST;
                  end
               end
            end
            S_FIRST: begin
               lo_entry_ff <= rd_data;
               hi_entry_ff <= rd_data;
               if (single_ff || (query_ff <= rd_data.key_time)) begin
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_LAST;
               end
            end
            S_LAST: begin
               hi_entry_ff <= rd_data;
               hi_ff       <= last_ff;
               if (query_ff >= rd_data.key_time) begin
                  lo_entry_ff <= rd_data;
                  lo_ff       <= last_ff;
                  state_ff    <= S_MUL;
               end else begin
                  state_ff <= S_PROBE;
               end
            end
            S_PROBE: begin
               if ((hi_ff - lo_ff) > IW'(1)) begin
                  mid_ff   <= mid;
                  state_ff <= S_PROBE_CHK;
               end else if (div_ok) begin
                  rem_ff     <= num_in;
                  den_ff     <= den_in;
                  div_cnt_ff <= DCW'(FRAC_W - 1);
                  state_ff   <= S_DIV;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_PROBE_CHK: begin
               if (rd_data.key_time <= query_ff) begin
                  lo_ff       <= mid_ff;
                  lo_entry_ff <= rd_data;
               end else begin
                  hi_ff       <= mid_ff;
                  hi_entry_ff <= rd_data;
               end
               state_ff <= S_PROBE;
            end
            S_DIV: begin
               frac_ff <= {frac_ff[FRAC_W-2:0], rem_ge};
               rem_ff  <= rem_ge ? 32'(rem_shift - {1'b0, den_ff}) : rem_shift[31:0];
               if (div_cnt_ff == '0) begin
                  state_ff <= S_MUL;
               end else begin
                  div_cnt_ff <= div_cnt_ff - DCW'(1);
               end
            end
            S_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               unique case (comp_ff)
                  2'd0: rsp_data_ff.value_x <= comp_result;
                  2'd1: rsp_data_ff.value_y <= comp_result;
                  default: rsp_data_ff.value_z <= comp_result;
               endcase
               if (comp_ff == 2'd2) begin
                  rsp_data_ff.lower_index    <= SLOT_W'(lo_ff);
                  rsp_data_ff.upper_index    <= SLOT_W'(hi_ff);
                  rsp_data_ff.blend_fraction <= frac_ff;
                  state_ff                   <= S_IDLE;
               end else begin
                  comp_ff  <= comp_ff + 2'd1;
                  state_ff <= S_MUL;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat lasted more than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while the sequencer is still working");

   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.command == CMD_WRITE)) |=> (!busy && !rsp_valid))
      else $error("write command left the block busy or made a result");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.command == CMD_SAMPLE)) |=> busy)
      else $error("sample command did not start the sequencer");

   a_bracket: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (lo_ff < hi_ff))
      else $error("search bracket collapsed");
`endif

endmodule

`default_nettype wire
